>>> hdl/tdsp_pkg.sv
`timescale 1ns / 1ps

package tdsp_pkg;

    localparam int NUM_CPUS    = 16;
    localparam int STACK_DEPTH = 256;
    localparam int TASK_BITS   = 16;

    // handles travel on 16-bit ports, the stores keep TASK_W of them (TASK_BITS, at most 16)
    localparam int TASK_W  = (TASK_BITS < 16) ? TASK_BITS : 16;
    localparam int CPU_AW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int ADDR_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam logic [2:0] CMD_ADD_READY    = 3'd0;
    localparam logic [2:0] CMD_UNBLOCK      = 3'd1;
    localparam logic [2:0] CMD_TAKE         = 3'd2;
    localparam logic [2:0] CMD_IDLE_QUERY   = 3'd3;
    localparam logic [2:0] CMD_DISABLE      = 3'd4;
    localparam logic [2:0] CMD_REQUEST_POLL = 3'd5;
    localparam logic [2:0] CMD_RELEASE_POLL = 3'd6;

    localparam logic [3:0] OC_DONE      = 4'd0;
    localparam logic [3:0] OC_SUCCESSOR = 4'd1;
    localparam logic [3:0] OC_TO_POLLER = 4'd2;
    localparam logic [3:0] OC_QUEUED    = 4'd3;
    localparam logic [3:0] OC_TASK      = 4'd4;
    localparam logic [3:0] OC_NONE      = 4'd5;
    localparam logic [3:0] OC_CLAIMED   = 4'd6;
    localparam logic [3:0] OC_BUSY      = 4'd7;
    localparam logic [3:0] OC_RELEASED  = 4'd8;
    localparam logic [3:0] OC_NOT_OWNER = 4'd9;
    localparam logic [3:0] OC_FULL      = 4'd10;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [TASK_W-1:0] task_h;
        logic [3:0]        cpu;
        logic              cpu_ok;
        logic              succ_try;
        logic              want_wake;
        logic              may_idle;
        logic              force_req;
    } t_item;

    typedef struct packed {
        logic [3:0]  outcome;
        logic        task_valid;
        logic [15:0] task_out;
        logic [3:0]  target_cpu;
        logic        wake_idle;
        logic        mark_idle;
    } t_result;

endpackage

>>> hdl/task_dispatch_with_successor_and_poller_core.sv
`timescale 1ns / 1ps
// channel   direction  handshake         payload
// command   in         push / full       command, task_handle, cpu, cpu_given, child_hint,
//                                        want_wakeup, may_idle, force_req
// result    out        empty / pop       outcome, task_valid, task_out, target_cpu,
//                                        wake_idle, mark_idle
//
// in the execute unit a fetch state reads the stack tops from the stack memories
// (registered read), and an execute state updates the state and loads the result.
// a two-entry command queue sits between accept and execute, so push is taken
// while the result register waits for pop, until the queue is full.
// synchronous reset clears the counts, valid bits and polling slot at once; no clearing pass.

module task_dispatch_with_successor_and_poller_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_command,
    input  logic [15:0] i_task_handle,
    input  logic [3:0]  i_cpu,
    input  logic        i_cpu_given,
    input  logic        i_child_hint,
    input  logic        i_want_wakeup,
    input  logic        i_may_idle,
    input  logic        i_force_req,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_outcome,
    output logic        o_task_valid,
    output logic [15:0] o_task_out,
    output logic [3:0]  o_target_cpu,
    output logic        o_wake_idle,
    output logic        o_mark_idle
);
    import tdsp_pkg::*;

    logic    w_q_valid;
    t_item   w_q_item;
    logic    w_q_pop;
    logic    w_res_valid;
    t_result w_res;

    tdsp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .i_command     (i_command),
        .i_task_handle (i_task_handle),
        .i_cpu         (i_cpu),
        .i_cpu_given   (i_cpu_given),
        .i_child_hint  (i_child_hint),
        .i_want_wakeup (i_want_wakeup),
        .i_may_idle    (i_may_idle),
        .i_force_req   (i_force_req),
        .full          (full),
        .o_q_valid     (w_q_valid),
        .o_q_item      (w_q_item),
        .i_q_pop       (w_q_pop)
    );

    tdsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_q_pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_pop   (pop)
    );

    assign empty        = !w_res_valid;
    assign o_outcome    = w_res.outcome;
    assign o_task_valid = w_res.task_valid;
    assign o_task_out   = w_res.task_out;
    assign o_target_cpu = w_res.target_cpu;
    assign o_wake_idle  = w_res.wake_idle;
    assign o_mark_idle  = w_res.mark_idle;

endmodule

>>> hdl/tdsp_front.sv
`timescale 1ns / 1ps

module tdsp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            push,
    input  logic [2:0]      i_command,
    input  logic [15:0]     i_task_handle,
    input  logic [3:0]      i_cpu,
    input  logic            i_cpu_given,
    input  logic            i_child_hint,
    input  logic            i_want_wakeup,
    input  logic            i_may_idle,
    input  logic            i_force_req,
    output logic            full,
    output logic            o_q_valid,
    output tdsp_pkg::t_item o_q_item,
    input  logic            i_q_pop
);
    import tdsp_pkg::*;

    t_item            r_q [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0]  r_cnt, n_cnt;
    t_item            w_item;
    logic             w_wr;
    logic             w_rd;

    // classification of the incoming transaction
    always_comb begin
        w_item           = '0;
        w_item.cmd       = i_command;
        w_item.task_h    = i_task_handle[TASK_W-1:0];
        w_item.cpu       = i_cpu;
        w_item.cpu_ok    = (32'(i_cpu) < NUM_CPUS);
        w_item.succ_try  = (i_command == CMD_ADD_READY) && i_cpu_given && !i_child_hint
                           && (32'(i_cpu) < NUM_CPUS);
        w_item.want_wake = i_want_wakeup;
        w_item.may_idle  = i_may_idle;
        w_item.force_req = i_force_req;
    end

    assign full      = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_q[r_rd_ptr];
    assign w_wr      = push && !full;
    assign w_rd      = i_q_pop && o_q_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : Q_AW'(r_wr_ptr + 1'b1);
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : Q_AW'(r_rd_ptr + 1'b1);
        end
        n_cnt = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = Q_CW'(r_cnt + 1'b1);
        end else if (w_rd && !w_wr) begin
            n_cnt = Q_CW'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

endmodule

>>> hdl/tdsp_back.sv
`timescale 1ns / 1ps

module tdsp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  tdsp_pkg::t_item   i_q_item,
    output logic              o_q_pop,
    output logic              o_res_valid,
    output tdsp_pkg::t_result o_res,
    input  logic              i_res_pop
);
    import tdsp_pkg::*;

    localparam logic ST_FETCH = 1'b0;
    localparam logic ST_EXEC  = 1'b1;

    logic              r_state;
    t_item             r_item;

    logic [TASK_W-1:0] r_succ_task [NUM_CPUS];
    logic [NUM_CPUS-1:0] r_succ_valid, n_succ_valid;
    logic              r_poll_held, n_poll_held;
    logic [3:0]        r_poll_owner, n_poll_owner;

    logic [TASK_W-1:0] r_ready_mem [STACK_DEPTH];
    logic [TASK_W-1:0] r_unbl_mem  [STACK_DEPTH];
    logic [CNT_W-1:0]  r_rcnt, n_rcnt;
    logic [CNT_W-1:0]  r_ucnt, n_ucnt;
    logic [TASK_W-1:0] r_rtop;
    logic [TASK_W-1:0] r_utop;

    logic              r_out_valid;
    t_result           r_out, n_out;

    logic [CPU_AW-1:0] w_idx;
    logic              w_fetch;
    logic              w_commit;
    logic              w_has_succ, w_has_u, w_has_r;
    logic              w_rfull, w_ufull;
    logic [TASK_W-1:0] w_s_task;
    logic [TASK_W-1:0] w_serve_task;
    logic              w_succ_we;
    logic              w_rd_we, w_ub_we;
    logic [TASK_W-1:0] w_rd_wdata;

    assign w_fetch  = (r_state == ST_FETCH) && i_q_valid;
    assign w_commit = (r_state == ST_EXEC) && (!r_out_valid || i_res_pop);
    assign o_q_pop  = w_fetch;

    assign w_idx      = CPU_AW'(r_item.cpu);
    assign w_s_task   = r_succ_task[w_idx];
    assign w_has_succ = r_item.cpu_ok && r_succ_valid[w_idx];
    assign w_has_u    = (r_ucnt != '0);
    assign w_has_r    = (r_rcnt != '0);
    assign w_rfull    = (r_rcnt == CNT_W'(STACK_DEPTH));
    assign w_ufull    = (r_ucnt == CNT_W'(STACK_DEPTH));

    always_comb begin
        n_out          = '0;
        n_out.outcome  = OC_DONE;
        n_succ_valid   = r_succ_valid;
        n_poll_held    = r_poll_held;
        n_poll_owner   = r_poll_owner;
        n_rcnt         = r_rcnt;
        n_ucnt         = r_ucnt;
        w_succ_we      = 1'b0;
        w_rd_we        = 1'b0;
        w_ub_we        = 1'b0;
        w_rd_wdata     = r_item.task_h;

        // serve order: own successor slot, unblocked stack, ready stack
        if (w_has_succ) begin
            w_serve_task = w_s_task;
        end else if (w_has_u) begin
            w_serve_task = r_utop;
        end else begin
            w_serve_task = r_rtop;
        end

        case (r_item.cmd)
            CMD_ADD_READY, CMD_UNBLOCK: begin
                if (r_item.succ_try && !r_succ_valid[w_idx]) begin
                    w_succ_we           = 1'b1;
                    n_succ_valid[w_idx] = 1'b1;
                    n_out.outcome       = OC_SUCCESSOR;
                end else if (r_poll_held) begin
                    n_poll_held      = 1'b0;
                    n_out.outcome    = OC_TO_POLLER;
                    n_out.task_valid = 1'b1;
                    n_out.task_out   = 16'(r_item.task_h);
                    n_out.target_cpu = r_poll_owner;
                end else if (r_item.cmd == CMD_ADD_READY) begin
                    if (w_rfull) begin
                        n_out.outcome = OC_FULL;
                    end else begin
                        w_rd_we         = 1'b1;
                        n_rcnt          = CNT_W'(r_rcnt + 1'b1);
                        n_out.outcome   = OC_QUEUED;
                        n_out.wake_idle = r_item.want_wake;
                    end
                end else begin
                    if (w_ufull) begin
                        n_out.outcome = OC_FULL;
                    end else begin
                        w_ub_we       = 1'b1;
                        n_ucnt        = CNT_W'(r_ucnt + 1'b1);
                        n_out.outcome = OC_QUEUED;
                    end
                end
            end
            CMD_TAKE, CMD_REQUEST_POLL: begin
                if (w_has_succ || w_has_u || w_has_r) begin
                    if (w_has_succ) begin
                        n_succ_valid[w_idx] = 1'b0;
                    end else if (w_has_u) begin
                        n_ucnt = CNT_W'(r_ucnt - 1'b1);
                    end else begin
                        n_rcnt = CNT_W'(r_rcnt - 1'b1);
                    end
                    n_out.outcome    = OC_TASK;
                    n_out.task_valid = 1'b1;
                    n_out.task_out   = 16'(w_serve_task);
                    n_out.target_cpu = r_item.cpu;
                end else if (r_item.cmd == CMD_TAKE) begin
                    n_out.outcome   = OC_NONE;
                    n_out.mark_idle = r_item.may_idle;
                end else if (!r_poll_held) begin
                    n_poll_held   = 1'b1;
                    n_poll_owner  = r_item.cpu;
                    n_out.outcome = OC_CLAIMED;
                end else begin
                    n_out.outcome   = OC_BUSY;
                    n_out.mark_idle = 1'b1;
                end
            end
            CMD_IDLE_QUERY: begin
                n_out.wake_idle = r_item.force_req || w_has_r || w_has_u;
            end
            CMD_DISABLE: begin
                if (w_has_succ) begin
                    if (w_rfull) begin
                        n_out.outcome = OC_FULL;
                    end else begin
                        w_rd_we             = 1'b1;
                        w_rd_wdata          = w_s_task;
                        n_rcnt              = CNT_W'(r_rcnt + 1'b1);
                        n_succ_valid[w_idx] = 1'b0;
                    end
                end
            end
            CMD_RELEASE_POLL: begin
                if (r_poll_held && (r_poll_owner == r_item.cpu)) begin
                    n_poll_held     = 1'b0;
                    n_out.outcome   = OC_RELEASED;
                    n_out.mark_idle = 1'b1;
                end else begin
                    n_out.outcome = OC_NOT_OWNER;
                end
            end
            default: begin
                n_out.outcome = OC_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_FETCH;
            r_succ_valid <= '0;
            r_poll_held  <= 1'b0;
            r_poll_owner <= '0;
            r_rcnt       <= '0;
            r_ucnt       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_fetch) begin
                r_state <= ST_EXEC;
            end else if (w_commit) begin
                r_state <= ST_FETCH;
            end
            if (w_commit) begin
                r_succ_valid <= n_succ_valid;
                r_poll_held  <= n_poll_held;
                r_poll_owner <= n_poll_owner;
                r_rcnt       <= n_rcnt;
                r_ucnt       <= n_ucnt;
                r_out_valid  <= 1'b1;
            end else if (i_res_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fetch) begin
            r_item <= i_q_item;
        end
        if (w_commit) begin
            r_out <= n_out;
        end
        if (w_commit && w_succ_we) begin
            r_succ_task[w_idx] <= r_item.task_h;
        end
    end

    // stack memories: top read in fetch, push written in execute
    always_ff @(posedge i_clk) begin
        if (w_fetch) begin
            r_rtop <= r_ready_mem[ADDR_W'(r_rcnt - 1'b1)];
        end
        if (w_commit && w_rd_we) begin
            r_ready_mem[ADDR_W'(r_rcnt)] <= w_rd_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fetch) begin
            r_utop <= r_unbl_mem[ADDR_W'(r_ucnt - 1'b1)];
        end
        if (w_commit && w_ub_we) begin
            r_unbl_mem[ADDR_W'(r_ucnt)] <= r_item.task_h;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

>>> hdl/tdsp_checker.sv
`timescale 1ns / 1ps

module tdsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [3:0]  o_outcome,
    input logic        o_task_valid,
    input logic [15:0] o_task_out,
    input logic [3:0]  o_target_cpu,
    input logic        o_wake_idle
);
    import tdsp_pkg::*;

    // a waiting result holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_outcome) && $stable(o_task_out))
        else $error("result changed while stalled");

    // a task is carried only by a serve or a poller delivery
    a_task_oc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_task_valid == ((o_outcome == OC_TASK) || (o_outcome == OC_TO_POLLER)))
        else $error("task_valid does not match outcome");

    a_task_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_task_valid |-> (o_task_out == '0) && (o_target_cpu == '0))
        else $error("task fields not cleared");

    // wake requests come only from a queued add or an idle query
    a_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_wake_idle |-> (o_outcome == OC_QUEUED) || (o_outcome == OC_DONE))
        else $error("wake_idle with unexpected outcome");

endmodule

bind task_dispatch_with_successor_and_poller_core tdsp_checker u_tdsp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .empty        (empty),
    .pop          (pop),
    .o_outcome    (o_outcome),
    .o_task_valid (o_task_valid),
    .o_task_out   (o_task_out),
    .o_target_cpu (o_target_cpu),
    .o_wake_idle  (o_wake_idle)
);

>>> tb/task_dispatch_with_successor_and_poller_core_test.sv
`timescale 1ns / 1ps

module task_dispatch_with_successor_and_poller_core_test;

    import tdsp_pkg::*;

    localparam int          CLK_PERIOD = 8;
    localparam int          RUN_LIMIT  = 500000;
    localparam logic [2:0]  CMD_UNUSED = 3'd7;
    localparam t_result     NO_RES     = '0;

    typedef struct {
        logic [2:0]  cmd;
        logic [15:0] handle;
        logic [3:0]  cpu;
        bit          from_cpu;
        bit          child;
        bit          wake_req;
        bit          idle_ok;
        bit          force_wake;
    } t_cmd;

    typedef struct {
        t_cmd    stim;
        bit      typed;
        t_result want;
    } t_dir_row;

    typedef enum {
        MODE_MIX,
        MODE_FILL_READY,
        MODE_FILL_UNBLK,
        MODE_DRAIN,
        MODE_POLL
    } t_load_mode;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [2:0]  i_command;
    logic [15:0] i_task_handle;
    logic [3:0]  i_cpu;
    logic        i_cpu_given;
    logic        i_child_hint;
    logic        i_want_wakeup;
    logic        i_may_idle;
    logic        i_force_req;
    logic        empty;
    logic        pop;
    logic [3:0]  o_outcome;
    logic        o_task_valid;
    logic [15:0] o_task_out;
    logic [3:0]  o_target_cpu;
    logic        o_wake_idle;
    logic        o_mark_idle;

    // dispatcher state as predicted
    logic [TASK_W-1:0] succ_task [NUM_CPUS];
    bit                succ_held [NUM_CPUS];
    bit                poll_taken;
    logic [3:0]        poll_cpu;
    logic [TASK_W-1:0] ready_stack [STACK_DEPTH];
    int unsigned       ready_n;
    logic [TASK_W-1:0] unblk_stack [STACK_DEPTH];
    int unsigned       unblk_n;

    t_result     awaited_outcomes [$];
    int unsigned errors;
    int unsigned cmds_sent;
    int unsigned results_checked;
    int unsigned full_seen;
    int unsigned poller_hits;
    int unsigned cycles;
    bit          no_idle;

    t_dir_row directed_rows [24] = '{
        '{'{CMD_IDLE_QUERY,   16'h0000, 4'd0,  0, 0, 0, 0, 0}, 1,
          '{OC_DONE, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0}},
        '{'{CMD_IDLE_QUERY,   16'h0000, 4'd0,  0, 0, 0, 0, 1}, 1,
          '{OC_DONE, 1'b0, 16'h0000, 4'd0, 1'b1, 1'b0}},
        '{'{CMD_TAKE,         16'h0000, 4'd3,  0, 0, 0, 1, 0}, 1,
          '{OC_NONE, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b1}},
        '{'{CMD_TAKE,         16'h0000, 4'd3,  0, 0, 0, 0, 0}, 1,
          '{OC_NONE, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0}},
        '{'{CMD_RELEASE_POLL, 16'h0000, 4'd2,  0, 0, 0, 0, 0}, 1,
          '{OC_NOT_OWNER, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0}},
        '{'{CMD_REQUEST_POLL, 16'h0000, 4'd5,  0, 0, 0, 0, 0}, 1,
          '{OC_CLAIMED, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0}},
        '{'{CMD_REQUEST_POLL, 16'h0000, 4'd5,  0, 0, 0, 0, 0}, 1,
          '{OC_BUSY, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b1}},
        '{'{CMD_RELEASE_POLL, 16'h0000, 4'd6,  0, 0, 0, 0, 0}, 1,
          '{OC_NOT_OWNER, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0}},
        '{'{CMD_ADD_READY,    16'hFFFF, 4'd0,  0, 0, 0, 0, 0}, 1,
          '{OC_TO_POLLER, 1'b1, 16'hFFFF, 4'd5, 1'b0, 1'b0}},
        '{'{CMD_REQUEST_POLL, 16'h0000, 4'd15, 0, 0, 0, 0, 0}, 1,
          '{OC_CLAIMED, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0}},
        '{'{CMD_RELEASE_POLL, 16'h0000, 4'd15, 0, 0, 0, 0, 0}, 1,
          '{OC_RELEASED, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b1}},
        '{'{CMD_ADD_READY,    16'h0000, 4'd15, 1, 0, 0, 0, 0}, 1,
          '{OC_SUCCESSOR, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0}},
        '{'{CMD_ADD_READY,    16'h1234, 4'd15, 1, 0, 1, 0, 0}, 0, NO_RES},
        '{'{CMD_ADD_READY,    16'hABCD, 4'd0,  1, 1, 0, 0, 0}, 0, NO_RES},
        '{'{CMD_UNBLOCK,      16'h5A5A, 4'd7,  0, 0, 0, 0, 0}, 0, NO_RES},
        '{'{CMD_IDLE_QUERY,   16'h0000, 4'd0,  0, 0, 0, 0, 0}, 0, NO_RES},
        '{'{CMD_DISABLE,      16'h0000, 4'd15, 0, 0, 0, 0, 0}, 0, NO_RES},
        '{'{CMD_DISABLE,      16'h0000, 4'd15, 0, 0, 0, 0, 0}, 1,
          '{OC_DONE, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0}},
        '{'{CMD_TAKE,         16'h0000, 4'd15, 0, 0, 0, 0, 0}, 0, NO_RES},
        '{'{CMD_REQUEST_POLL, 16'h0000, 4'd1,  0, 0, 0, 0, 0}, 0, NO_RES},
        '{'{CMD_UNUSED,       16'hFFFF, 4'd15, 1, 1, 1, 1, 1}, 1,
          '{OC_DONE, 1'b0, 16'h0000, 4'd0, 1'b0, 1'b0}},
        '{'{CMD_TAKE,         16'h0000, 4'd0,  0, 0, 0, 0, 0}, 0, NO_RES},
        '{'{CMD_TAKE,         16'h0000, 4'd0,  0, 0, 0, 0, 0}, 0, NO_RES},
        '{'{CMD_TAKE,         16'h0000, 4'd0,  0, 0, 0, 1, 0}, 0, NO_RES}
    };

    t_load_mode  phase_mode [6] = '{MODE_MIX, MODE_FILL_READY, MODE_DRAIN,
                                    MODE_POLL, MODE_FILL_UNBLK, MODE_DRAIN};
    int unsigned phase_len  [6] = '{120, 340, 120, 100, 330, 200};

    task_dispatch_with_successor_and_poller_core DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .push          (push),
        .full          (full),
        .i_command     (i_command),
        .i_task_handle (i_task_handle),
        .i_cpu         (i_cpu),
        .i_cpu_given   (i_cpu_given),
        .i_child_hint  (i_child_hint),
        .i_want_wakeup (i_want_wakeup),
        .i_may_idle    (i_may_idle),
        .i_force_req   (i_force_req),
        .empty         (empty),
        .pop           (pop),
        .o_outcome     (o_outcome),
        .o_task_valid  (o_task_valid),
        .o_task_out    (o_task_out),
        .o_target_cpu  (o_target_cpu),
        .o_wake_idle   (o_wake_idle),
        .o_mark_idle   (o_mark_idle)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // successor slot first, then unblocked stack, then ready stack
    function automatic bit serve_task(input logic [3:0] cpu, output logic [TASK_W-1:0] got);
        got = '0;
        if (int'(cpu) < NUM_CPUS && succ_held[cpu]) begin
            succ_held[cpu] = 1'b0;
            got = succ_task[cpu];
            return 1'b1;
        end
        if (unblk_n > 0) begin
            unblk_n--;
            got = unblk_stack[unblk_n];
            return 1'b1;
        end
        if (ready_n > 0) begin
            ready_n--;
            got = ready_stack[ready_n];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_result dispatch_predict(input t_cmd c);
        t_result           r;
        logic [TASK_W-1:0] h;
        logic [TASK_W-1:0] got;
        bit                cpu_ok;
        r      = '0;
        h      = c.handle[TASK_W-1:0];
        cpu_ok = int'(c.cpu) < NUM_CPUS;
        case (c.cmd)
            CMD_ADD_READY, CMD_UNBLOCK: begin
                if (c.cmd == CMD_ADD_READY && c.from_cpu && !c.child && cpu_ok &&
                    !succ_held[c.cpu]) begin
                    succ_task[c.cpu] = h;
                    succ_held[c.cpu] = 1'b1;
                    r.outcome        = OC_SUCCESSOR;
                end else if (poll_taken) begin
                    poll_taken   = 1'b0;
                    r.outcome    = OC_TO_POLLER;
                    r.task_valid = 1'b1;
                    r.task_out   = 16'(h);
                    r.target_cpu = poll_cpu;
                end else if (c.cmd == CMD_ADD_READY) begin
                    if (ready_n < STACK_DEPTH) begin
                        ready_stack[ready_n] = h;
                        ready_n++;
                        r.outcome   = OC_QUEUED;
                        r.wake_idle = c.wake_req;
                    end else begin
                        r.outcome = OC_FULL;
                    end
                end else begin
                    if (unblk_n < STACK_DEPTH) begin
                        unblk_stack[unblk_n] = h;
                        unblk_n++;
                        r.outcome = OC_QUEUED;
                    end else begin
                        r.outcome = OC_FULL;
                    end
                end
            end
            CMD_TAKE: begin
                if (serve_task(c.cpu, got)) begin
                    r.outcome    = OC_TASK;
                    r.task_valid = 1'b1;
                    r.task_out   = 16'(got);
                    r.target_cpu = c.cpu;
                end else begin
                    r.outcome   = OC_NONE;
                    r.mark_idle = c.idle_ok;
                end
            end
            CMD_IDLE_QUERY: begin
                r.outcome   = OC_DONE;
                r.wake_idle = c.force_wake || ready_n != 0 || unblk_n != 0;
            end
            CMD_DISABLE: begin
                r.outcome = OC_DONE;
                if (cpu_ok && succ_held[c.cpu]) begin
                    // slot keeps its task when the ready stack is full
                    if (ready_n < STACK_DEPTH) begin
                        ready_stack[ready_n] = succ_task[c.cpu];
                        ready_n++;
                        succ_held[c.cpu] = 1'b0;
                    end else begin
                        r.outcome = OC_FULL;
                    end
                end
            end
            CMD_REQUEST_POLL: begin
                if (serve_task(c.cpu, got)) begin
                    r.outcome    = OC_TASK;
                    r.task_valid = 1'b1;
                    r.task_out   = 16'(got);
                    r.target_cpu = c.cpu;
                end else if (!poll_taken) begin
                    poll_taken = 1'b1;
                    poll_cpu   = c.cpu;
                    r.outcome  = OC_CLAIMED;
                end else begin
                    r.outcome   = OC_BUSY;
                    r.mark_idle = 1'b1;
                end
            end
            CMD_RELEASE_POLL: begin
                if (poll_taken && poll_cpu == c.cpu) begin
                    poll_taken  = 1'b0;
                    r.outcome   = OC_RELEASED;
                    r.mark_idle = 1'b1;
                end else begin
                    r.outcome = OC_NOT_OWNER;
                end
            end
            default: r.outcome = OC_DONE;
        endcase
        return r;
    endfunction

    function automatic t_cmd random_cmd(input t_load_mode m);
        t_cmd        c;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        case (m)
            MODE_FILL_READY:
                c.cmd = pick < 90 ? CMD_ADD_READY : pick < 95 ? CMD_DISABLE :
                        pick < 98 ? CMD_IDLE_QUERY : CMD_TAKE;
            MODE_FILL_UNBLK:
                c.cmd = pick < 90 ? CMD_UNBLOCK : pick < 94 ? CMD_ADD_READY :
                        pick < 97 ? CMD_IDLE_QUERY : CMD_TAKE;
            MODE_DRAIN:
                c.cmd = pick < 45 ? CMD_TAKE : pick < 75 ? CMD_REQUEST_POLL :
                        pick < 85 ? CMD_RELEASE_POLL : pick < 90 ? CMD_IDLE_QUERY :
                        pick < 95 ? CMD_DISABLE : CMD_ADD_READY;
            MODE_POLL:
                c.cmd = pick < 35 ? CMD_REQUEST_POLL : pick < 60 ? CMD_RELEASE_POLL :
                        pick < 75 ? CMD_ADD_READY : pick < 90 ? CMD_UNBLOCK : CMD_TAKE;
            default:
                c.cmd = pick < 20 ? CMD_ADD_READY : pick < 35 ? CMD_UNBLOCK :
                        pick < 55 ? CMD_TAKE : pick < 63 ? CMD_IDLE_QUERY :
                        pick < 73 ? CMD_DISABLE : pick < 85 ? CMD_REQUEST_POLL :
                        pick < 95 ? CMD_RELEASE_POLL : CMD_UNUSED;
        endcase
        c.handle = 16'($urandom);
        // few processors while polling so that owners meet again
        c.cpu = (m == MODE_POLL) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
        // mostly main-task adds while filling, so the ready stack gets the pushes
        c.from_cpu   = (m == MODE_FILL_READY) ? ($urandom_range(0, 3) == 0)
                                              : 1'($urandom_range(0, 1));
        c.child      = 1'($urandom_range(0, 1));
        c.wake_req   = 1'($urandom_range(0, 1));
        c.idle_ok    = 1'($urandom_range(0, 1));
        c.force_wake = 1'($urandom_range(0, 1));
        return c;
    endfunction

    task automatic send_cmd(input t_cmd c, input bit typed, input t_result want);
        int unsigned gap;
        t_result     predicted;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push          <= 1'b1;
        i_command     <= c.cmd;
        i_task_handle <= c.handle;
        i_cpu         <= c.cpu;
        i_cpu_given   <= c.from_cpu;
        i_child_hint  <= c.child;
        i_want_wakeup <= c.wake_req;
        i_may_idle    <= c.idle_ok;
        i_force_req   <= c.force_wake;
        forever begin
            @(posedge clk);
            if (!full)
                break;
        end
        // state moves on for every transaction, typed rows keep their own result
        predicted = dispatch_predict(c);
        awaited_outcomes.push_back(typed ? want : predicted);
        cmds_sent++;
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin : result_check
        t_result want;
        if (rst_n && pop && !empty) begin
            if (awaited_outcomes.size() == 0) begin
                $error("result transaction with nothing outstanding, outcome %0d", o_outcome);
                errors++;
            end else begin
                want = awaited_outcomes[0];
                awaited_outcomes.delete(0);
                compare_field("outcome",    want.outcome,    o_outcome);
                compare_field("task_valid", want.task_valid, o_task_valid);
                compare_field("task_out",   want.task_out,   o_task_out);
                compare_field("target_cpu", want.target_cpu, o_target_cpu);
                compare_field("wake_idle",  want.wake_idle,  o_wake_idle);
                compare_field("mark_idle",  want.mark_idle,  o_mark_idle);
                results_checked++;
                if (want.outcome == OC_FULL)
                    full_seen++;
                if (want.outcome == OC_TO_POLLER)
                    poller_hits++;
            end
        end
    end

    initial begin : result_drain
        int unsigned stall_left;
        stall_left = 0;
        pop        = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else begin
                pop <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    initial begin : watchdog
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycles, awaited_outcomes.size());
        $display("task_dispatch_with_successor_and_poller_core: mismatch");
        $finish;
    end

    initial begin : stimulus
        clk             = 1'b0;
        rst_n           = 1'b0;
        push            = 1'b0;
        i_command       = CMD_ADD_READY;
        i_task_handle   = '0;
        i_cpu           = '0;
        i_cpu_given     = 1'b0;
        i_child_hint    = 1'b0;
        i_want_wakeup   = 1'b0;
        i_may_idle      = 1'b0;
        i_force_req     = 1'b0;
        errors          = 0;
        cmds_sent       = 0;
        results_checked = 0;
        full_seen       = 0;
        poller_hits     = 0;
        no_idle         = 1'b0;
        succ_held       = '{default: 1'b0};
        poll_taken      = 1'b0;
        poll_cpu        = '0;
        ready_n         = 0;
        unblk_n         = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_cmd(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

        foreach (phase_mode[p]) begin
            // some phases run back to back with no gaps on either side
            no_idle = (p == 3) || ($urandom_range(0, 3) == 0);
            repeat (phase_len[p])
                send_cmd(random_cmd(phase_mode[p]), 1'b0, NO_RES);
        end

        @(negedge clk);
        push       <= 1'b0;
        no_idle    = 1'b0;
        while (awaited_outcomes.size() != 0)
            @(posedge clk);
        // catch any stray transaction after the last one expected
        repeat (12) @(posedge clk);

        $display("%0d commands sent through all seven operations, %0d results checked",
                 cmds_sent, results_checked);
        $display("%0d pushes refused on a full stack, %0d tasks handed straight to a poller",
                 full_seen, poller_hits);
        if (errors == 0)
            $display("task_dispatch_with_successor_and_poller_core: match");
        else
            $display("task_dispatch_with_successor_and_poller_core: mismatch");
        $finish;
    end

endmodule
